// ===== rtl/core/adcas_pkg.sv =====
// ----------------------------------------------------------------------------
// adcas_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the two-channel averaging and voltage scaling core.
// ----------------------------------------------------------------------------
package adcas_pkg;

    // Sample and accumulator widths
    localparam int SAMPLE_WIDTH = 24;
    localparam int MAX_AVERAGE  = 50;
    localparam int ACC_W        = 31;
    localparam int CNT_W        = 6;
    localparam int RES_W        = 5;
    localparam int GAIN_W       = 3;
    localparam int VOLT_W       = 21;
    localparam int MAX_DROP     = 12;
    localparam int DROP_W       = 4;
    localparam int SHIFT_W      = 5;

    // Full scale in microvolts: 1.197 V / 1.5
    localparam int FULL_SCALE_UV = 798000;
    localparam int SCALE_W       = 21;
    localparam int PROD_W        = SAMPLE_WIDTH + SCALE_W;

    // Divider step counter
    localparam int STEP_W = $clog2(ACC_W);

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + VOLT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH0     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH1     = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted request
        logic accum;     // add sample to channel sum, start divide on full burst
        logic sat;       // saturate quotient, drop low bits
        logic mul;       // multiply by full scale
        logic out_load;  // shift to microvolts, load output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic complete;  // burst of the current channel is full
        logic div_done;  // quotient is ready
        logic out_free;  // output register can take a result
    } t_dp_stat;

endpackage

// ===== rtl/core/adcas_div.sv =====
// ----------------------------------------------------------------------------
// adcas_div
// Restoring divider of the signed burst sum by the unsigned sample count,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module adcas_div
    import adcas_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [ACC_W-1:0]   r_work;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_div;
    logic               r_neg;

    logic [CNT_W:0]     w_trial;
    logic               w_fits;
    logic [CNT_W:0]     w_rem_next;

    // Trial subtract of one step
    assign w_trial    = {r_rem, r_work[ACC_W-1]};
    assign w_fits     = (w_trial >= {1'b0, r_div});
    assign w_rem_next = w_fits ? (w_trial - {1'b0, r_div}) : w_trial;

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift dividend magnitude out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[ACC_W-1];
            r_work <= i_dividend[ACC_W-1] ? unsigned'(-i_dividend) : unsigned'(i_dividend);
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[ACC_W-2:0], w_fits};
            r_rem  <= w_rem_next[CNT_W-1:0];
        end
    end

    // Restore the sign of the quotient
    assign o_quotient = r_neg ? -signed'(r_work) : signed'(r_work);
    assign o_done     = r_done;

endmodule

// ===== rtl/core/adcas_dp.sv =====
// ----------------------------------------------------------------------------
// adcas_dp
// Datapath: configuration registers, per-channel sums and fills, divider,
// resolution drop, microvolt scaling and the output register.
// ----------------------------------------------------------------------------
module adcas_dp
    import adcas_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  t_dp_cmd                        i_cmd,
    output t_dp_stat                       o_stat,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_code,
    input  logic                           i_channel,
    input  logic                           i_m_tready,
    output logic                           o_m_valid,
    output logic                           o_out_channel,
    output logic signed [SAMPLE_WIDTH-1:0] o_average_code,
    output logic signed [VOLT_W-1:0]       o_voltage_uv
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 << (SAMPLE_WIDTH - 1)));
    localparam logic signed [SCALE_W-1:0] SCALE = SCALE_W'(FULL_SCALE_UV);

    // Configuration
    logic [CNT_W-1:0]  r_cfg_count;
    logic [RES_W-1:0]  r_cfg_res;
    logic [GAIN_W-1:0] r_cfg_gain0;
    logic [GAIN_W-1:0] r_cfg_gain1;

    // Channel state and working registers
    logic signed [ACC_W-1:0]        r_acc [2];
    logic [CNT_W-1:0]               r_fill [2];
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_ch;
    logic signed [SAMPLE_WIDTH-1:0] r_code;
    logic signed [SAMPLE_WIDTH-1:0] r_scaled;
    logic signed [PROD_W-1:0]       r_prod;

    // Output register
    logic                           r_o_valid;
    logic                           r_o_ch;
    logic signed [SAMPLE_WIDTH-1:0] r_o_code;
    logic signed [VOLT_W-1:0]       r_o_volt;

    logic [CNT_W-1:0]               w_count;
    logic signed [ACC_W-1:0]        w_sum;
    logic [CNT_W:0]                 w_fill_inc;
    logic                           w_complete;
    logic                           w_div_start;
    logic                           w_div_done;
    logic signed [ACC_W-1:0]        w_quot;
    logic signed [SAMPLE_WIDTH-1:0] w_avg;
    logic [RES_W-1:0]               w_drop_full;
    logic [DROP_W-1:0]              w_drop;
    logic signed [SAMPLE_WIDTH-1:0] w_code;
    logic [GAIN_W-1:0]              w_gain;
    logic [SHIFT_W-1:0]             w_shift;
    logic signed [PROD_W-1:0]       w_volt_full;
    logic                           w_out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= CNT_W'(1);
            r_cfg_res   <= RES_W'(SAMPLE_WIDTH);
            r_cfg_gain0 <= '0;
            r_cfg_gain1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_COUNT: r_cfg_count <= i_cfg_data;
                CFG_RESOLUTION:   r_cfg_res   <= i_cfg_data[RES_W-1:0];
                CFG_GAIN_CH0:     r_cfg_gain0 <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_CH1:     r_cfg_gain1 <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the sample count to one through the maximum
    always_comb begin
        if (r_cfg_count == '0) begin
            w_count = CNT_W'(1);
        end else if (r_cfg_count > CNT_W'(MAX_AVERAGE)) begin
            w_count = CNT_W'(MAX_AVERAGE);
        end else begin
            w_count = r_cfg_count;
        end
    end

    // Add the sample and check for a full burst
    assign w_sum       = r_acc[r_ch] + ACC_W'(r_sample);
    assign w_fill_inc  = {1'b0, r_fill[r_ch]} + (CNT_W+1)'(1);
    assign w_complete  = (w_fill_inc >= {1'b0, w_count});
    assign w_div_start = i_cmd.accum && w_complete;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_raw_code;
            r_ch     <= i_channel;
        end
    end

    // Hold or clear the channel sums and fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0]  <= '0;
            r_acc[1]  <= '0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
        end else if (i_cmd.accum) begin
            if (w_complete) begin
                r_acc[r_ch]  <= '0;
                r_fill[r_ch] <= '0;
            end else begin
                r_acc[r_ch]  <= w_sum;
                r_fill[r_ch] <= w_fill_inc[CNT_W-1:0];
            end
        end
    end

    adcas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Saturate the quotient to the sample range
    always_comb begin
        if (w_quot > SAT_HI) begin
            w_avg = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (w_quot < SAT_LO) begin
            w_avg = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            w_avg = w_quot[SAMPLE_WIDTH-1:0];
        end
    end

    // Number of low bits to drop
    assign w_drop_full = RES_W'(SAMPLE_WIDTH) - r_cfg_res;
    always_comb begin
        if (r_cfg_res >= RES_W'(SAMPLE_WIDTH)) begin
            w_drop = '0;
        end else if (r_cfg_res < RES_W'(SAMPLE_WIDTH - MAX_DROP)) begin
            w_drop = DROP_W'(MAX_DROP);
        end else begin
            w_drop = w_drop_full[DROP_W-1:0];
        end
    end

    assign w_code = w_avg >>> w_drop;

    // Reduce, multiply by full scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.sat) begin
            r_code   <= w_code;
            r_scaled <= w_code <<< w_drop;
        end
        if (i_cmd.mul) begin
            r_prod <= r_scaled * SCALE;
        end
    end

    // Divide by two to the 23 plus gain
    assign w_gain      = r_ch ? r_cfg_gain1 : r_cfg_gain0;
    assign w_shift     = SHIFT_W'(SAMPLE_WIDTH - 1) + SHIFT_W'(w_gain);
    assign w_volt_full = r_prod >>> w_shift;

    // Output register
    assign w_out_free = !r_o_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ch   <= r_ch;
            r_o_code <= r_code;
            r_o_volt <= w_volt_full[VOLT_W-1:0];
        end
    end

    assign o_stat.complete = w_complete;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_m_valid      = r_o_valid;
    assign o_out_channel  = r_o_ch;
    assign o_average_code = r_o_code;
    assign o_voltage_uv   = r_o_volt;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || i_m_tready))
        else $error("output register overwritten while a result waits");

    // Fills stay below the largest burst
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] < CNT_W'(MAX_AVERAGE)) && (r_fill[1] < CNT_W'(MAX_AVERAGE)))
        else $error("channel fill out of range");

    // A full burst clears its channel
    a_burst_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> ((r_fill[r_ch] == '0) && (r_acc[r_ch] == '0)))
        else $error("channel state not cleared after a full burst");

    // Saturation only follows a finished divide
    a_sat_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sat |-> $past(w_div_done))
        else $error("quotient used before divide finished");

endmodule

// ===== rtl/core/adcas_ctrl.sv =====
// ----------------------------------------------------------------------------
// adcas_ctrl
// Controller: accepts a request, sequences accumulate and, on a full burst,
// divide, reduce, multiply and output load.
// ----------------------------------------------------------------------------
module adcas_ctrl
    import adcas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SAT  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_stat.complete ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);

endmodule

// ===== rtl/core/adc_average_scale_to_voltage_core.sv =====
// ----------------------------------------------------------------------------
// adc_average_scale_to_voltage_core
// Two-channel boxcar averager of converter codes with resolution drop and
// conversion to microvolts.
//
//  channel   dir  fields (low bit up)                       handshake
//  s_axis    in   tdata: raw_code[23:0]; tuser: channel     tvalid/tready
//  m_axis    out  tdata: average_code[23:0],                tvalid/tready
//                 voltage_uv[44:24], zero[47:45];
//                 tuser: out_channel
//  cfg       in   idx 0..3, data[5:0]                       i_cfg_we
//
// A sample that does not complete a burst is accepted, then accumulated.
// A sample that completes a burst is accepted and accumulated, then takes 31
// restoring divider steps plus done, reduce, multiply and output load.
// Reset clears the channel sums and fills at once; no clearing pass.
// The output register holds a result while m_axis_tready is low; the next
// request is accepted meanwhile, and a new result waits until it is taken.
// ----------------------------------------------------------------------------
module adc_average_scale_to_voltage_core
    import adcas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // raw_code[23:0]
    input  logic                   s_axis_tuser,   // channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // average_code[23:0], voltage_uv[44:24]
    output logic                   m_axis_tuser    // out_channel
);

    t_dp_cmd                        w_cmd;
    t_dp_stat                       w_stat;
    logic signed [SAMPLE_WIDTH-1:0] w_average_code;
    logic signed [VOLT_W-1:0]       w_voltage_uv;

    adcas_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    adcas_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_raw_code     (signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_channel      (s_axis_tuser),
        .i_m_tready     (m_axis_tready),
        .o_m_valid      (m_axis_tvalid),
        .o_out_channel  (m_axis_tuser),
        .o_average_code (w_average_code),
        .o_voltage_uv   (w_voltage_uv)
    );

    // Pack result fields, pad to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W - SAMPLE_WIDTH - VOLT_W){1'b0}},
                           w_voltage_uv, w_average_code};

endmodule
